[rtl/frlc_pkg.sv]
// frame replacement package: frame count, widths, command codes, policy modes and sequencer states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package frlc_pkg;

  localparam int unsigned FRAMES = 32;
  localparam int unsigned IDX_W  = $clog2(FRAMES);
  localparam int unsigned CNT_W  = $clog2(FRAMES + 1);
  localparam int unsigned TIME_W = 32;
  localparam int unsigned PAGE_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_ALLOC = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic {
    MODE_LRU   = 1'b0,
    MODE_CLOCK = 1'b1
  } mode_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CLOCK = 5'b00100,
    S_RD    = 5'b01000,
    S_WR    = 5'b10000
  } state_e;

endpackage
`default_nettype wire

[rtl/frlc_ram.sv]
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module frlc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/frame_replacement_lru_clock_m.sv]
// frame replacement unit: occupancy, use and modified bits, lru times, clock-m hand
// depends on frlc_pkg and frlc_ram
//
// channel   direction  signals                                          handshake
// command   in         command_i frame_index_i page_id_i now_i          start && !busy
// result    out        chosen_frame_o evicted_o evicted_page_o write_back_o  result_valid_o
// config    in         cfg_data_i                                       cfg_valid_i && cfg_ready_o
//
// read and write accesses are handled in idle without going busy. an allocate scans frames one per cycle through
// the shared time compare and stops at the first free frame; a full set in lru mode takes
// the oldest time, in clock-m mode the hand steps one frame per cycle until it finds a victim.
// reset clears all bits, times (per-entry valid bits), hand and mode; no clearing pass.
// the result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module frame_replacement_lru_clock_m (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  command_i,
  input  wire logic [4:0]                  frame_index_i,
  input  wire logic [frlc_pkg::PAGE_W-1:0] page_id_i,
  input  wire logic [frlc_pkg::TIME_W-1:0] now_i,
  output logic                             result_valid_o,
  output logic [4:0]                       chosen_frame_o,
  output logic                             evicted_o,
  output logic [frlc_pkg::PAGE_W-1:0]      evicted_page_o,
  output logic                             write_back_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic                        cfg_data_i
);

  frlc_pkg::state_e state_q, state_d;
  frlc_pkg::mode_e  mode_q, mode_d;

  logic [frlc_pkg::FRAMES-1:0] occ_q, occ_d;
  logic [frlc_pkg::FRAMES-1:0] use_q, use_d;
  logic [frlc_pkg::FRAMES-1:0] dirty_q, dirty_d;
  logic [frlc_pkg::FRAMES-1:0] tvld_q, tvld_d;

  frlc_pkg::idx_t hand_q, hand_d;
  frlc_pkg::idx_t start_hand_q, start_hand_d;
  logic           laps_q, laps_d;
  frlc_pkg::cnt_t cnt_q, cnt_d;
  logic           cmp_vld_q, cmp_vld_d;
  frlc_pkg::idx_t cmp_idx_q, cmp_idx_d;
  frlc_pkg::idx_t best_idx_q, best_idx_d;
  frlc_pkg::idx_t victim_q, victim_d;
  logic           res_vld_q, res_vld_d;

  logic [frlc_pkg::TIME_W-1:0] best_time_q, best_time_d;
  logic [frlc_pkg::PAGE_W-1:0] page_q, page_d;
  logic [frlc_pkg::TIME_W-1:0] now_q, now_d;
  logic [4:0]                  out_frame_q, out_frame_d;
  logic                        out_evict_q, out_evict_d;
  logic [frlc_pkg::PAGE_W-1:0] out_page_q, out_page_d;
  logic                        out_wb_q, out_wb_d;

  // time ram and page ram ports
  logic                        t_we;
  frlc_pkg::idx_t              t_waddr;
  logic [frlc_pkg::TIME_W-1:0] t_wdata;
  frlc_pkg::idx_t              t_raddr;
  logic [frlc_pkg::TIME_W-1:0] t_rdata;
  logic                        p_we;
  logic [frlc_pkg::PAGE_W-1:0] p_rdata;

  logic [frlc_pkg::TIME_W-1:0] cmp_time;
  frlc_pkg::idx_t              acc_idx;
  frlc_pkg::idx_t              scan_idx;
  frlc_pkg::idx_t              hand_nxt;
  logic                        clk_hit;

  frlc_ram #(
    .WIDTH(frlc_pkg::TIME_W),
    .DEPTH(frlc_pkg::FRAMES)
  ) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(t_waddr),
    .wdata_i(t_wdata),
    .raddr_i(t_raddr),
    .rdata_o(t_rdata)
  );

  frlc_ram #(
    .WIDTH(frlc_pkg::PAGE_W),
    .DEPTH(frlc_pkg::FRAMES)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(victim_q),
    .wdata_i(page_q),
    .raddr_i(victim_q),
    .rdata_o(p_rdata)
  );

  assign busy           = (state_q != frlc_pkg::S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_vld_q;
  assign chosen_frame_o = out_frame_q;
  assign evicted_o      = out_evict_q;
  assign evicted_page_o = out_page_q;
  assign write_back_o   = out_wb_q;

  assign acc_idx  = frlc_pkg::IDX_W'(frame_index_i);
  assign scan_idx = cnt_q[frlc_pkg::IDX_W-1:0];
  assign cmp_time = tvld_q[cmp_idx_q] ? t_rdata : '0;
  assign hand_nxt = (32'(hand_q) == frlc_pkg::FRAMES - 1) ? '0 : hand_q + 1'b1;
  assign clk_hit  = occ_q[hand_q] && !use_q[hand_q] && (!dirty_q[hand_q] || laps_q);
  assign t_raddr  = scan_idx;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    occ_d        = occ_q;
    use_d        = use_q;
    dirty_d      = dirty_q;
    tvld_d       = tvld_q;
    hand_d       = hand_q;
    start_hand_d = start_hand_q;
    laps_d       = laps_q;
    cnt_d        = cnt_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = scan_idx;
    best_idx_d   = best_idx_q;
    best_time_d  = best_time_q;
    victim_d     = victim_q;
    res_vld_d    = 1'b0;
    page_d       = page_q;
    now_d        = now_q;
    out_frame_d  = out_frame_q;
    out_evict_d  = out_evict_q;
    out_page_d   = out_page_q;
    out_wb_d     = out_wb_q;
    t_we         = 1'b0;
    t_waddr      = victim_q;
    t_wdata      = now_q;
    p_we         = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      mode_d = frlc_pkg::mode_e'(cfg_data_i);
    end

    // running minimum over the time words coming out of the ram
    if (cmp_vld_q && (cmp_idx_q == '0 || cmp_time < best_time_q)) begin
      best_time_d = cmp_time;
      best_idx_d  = cmp_idx_q;
    end

    case (state_q)
      frlc_pkg::S_IDLE: begin
        if (start) begin
          page_d = page_id_i;
          now_d  = now_i;
          case (frlc_pkg::cmd_e'(command_i))
            frlc_pkg::CMD_READ: begin
              if (32'(frame_index_i) < frlc_pkg::FRAMES) begin
                use_d[acc_idx]  = 1'b1;
                tvld_d[acc_idx] = 1'b1;
                t_we            = 1'b1;
                t_waddr         = acc_idx;
                t_wdata         = now_i;
              end
            end
            frlc_pkg::CMD_WRITE: begin
              if (32'(frame_index_i) < frlc_pkg::FRAMES) begin
                use_d[acc_idx]   = 1'b1;
                dirty_d[acc_idx] = 1'b1;
              end
            end
            frlc_pkg::CMD_ALLOC: begin
              cnt_d   = '0;
              state_d = frlc_pkg::S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      frlc_pkg::S_SCAN: begin
        if (32'(cnt_q) < frlc_pkg::FRAMES) begin
          if (!occ_q[scan_idx]) begin
            victim_d = scan_idx;
            state_d  = frlc_pkg::S_RD;
          end else begin
            cmp_vld_d = 1'b1;
            cnt_d     = cnt_q + 1'b1;
          end
        end else if (mode_q == frlc_pkg::MODE_LRU) begin
          victim_d = best_idx_d;
          state_d  = frlc_pkg::S_RD;
        end else begin
          start_hand_d = hand_q;
          laps_d       = 1'b0;
          state_d      = frlc_pkg::S_CLOCK;
        end
      end
      frlc_pkg::S_CLOCK: begin
        hand_d = hand_nxt;
        if (clk_hit) begin
          victim_d = hand_q;
          state_d  = frlc_pkg::S_RD;
        end else begin
          use_d[hand_q] = 1'b0;
          if (hand_nxt == start_hand_q) begin
            laps_d = 1'b1;
          end
        end
      end
      frlc_pkg::S_RD: begin
        state_d = frlc_pkg::S_WR;
      end
      frlc_pkg::S_WR: begin
        out_frame_d       = 5'(victim_q);
        out_evict_d       = occ_q[victim_q];
        out_page_d        = occ_q[victim_q] ? p_rdata : '0;
        out_wb_d          = occ_q[victim_q] && dirty_q[victim_q];
        res_vld_d         = 1'b1;
        occ_d[victim_q]   = 1'b1;
        use_d[victim_q]   = 1'b1;
        dirty_d[victim_q] = 1'b0;
        tvld_d[victim_q]  = 1'b1;
        t_we              = 1'b1;
        p_we              = 1'b1;
        state_d           = frlc_pkg::S_IDLE;
      end
      default: begin
        state_d = frlc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= frlc_pkg::S_IDLE;
      mode_q       <= frlc_pkg::MODE_LRU;
      occ_q        <= '0;
      use_q        <= '0;
      dirty_q      <= '0;
      tvld_q       <= '0;
      hand_q       <= '0;
      start_hand_q <= '0;
      laps_q       <= 1'b0;
      cnt_q        <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      best_idx_q   <= '0;
      victim_q     <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      occ_q        <= occ_d;
      use_q        <= use_d;
      dirty_q      <= dirty_d;
      tvld_q       <= tvld_d;
      hand_q       <= hand_d;
      start_hand_q <= start_hand_d;
      laps_q       <= laps_d;
      cnt_q        <= cnt_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_idx_q    <= cmp_idx_d;
      best_idx_q   <= best_idx_d;
      victim_q     <= victim_d;
      res_vld_q    <= res_vld_d;
    end
  end

  // word payload
  always_ff @(posedge clk_i) begin
    best_time_q <= best_time_d;
    page_q      <= page_d;
    now_q       <= now_d;
    out_frame_q <= out_frame_d;
    out_evict_q <= out_evict_d;
    out_page_q  <= out_page_d;
    out_wb_q    <= out_wb_d;
  end

`ifndef NO_ASSERTIONS
  a_result_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_clock_all_occupied : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == frlc_pkg::S_CLOCK) |-> (&occ_q))
    else $error("clock search with a free frame");

  a_clean_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == frlc_pkg::S_WR) |=> (occ_q[victim_q] && use_q[victim_q] && !dirty_q[victim_q]))
    else $error("filled frame not clean");

  a_no_evict_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !evicted_o) |-> (evicted_page_o == '0 && !write_back_o))
    else $error("payload on a free frame result");
`endif

endmodule
`default_nettype wire

[test/frame_replacement_lru_clock_m_tb.sv]
// testbench for frame_replacement_lru_clock_m: directed and random command words in lru and
// clock-m modes, results checked against an in-bench frame table model
// depends on frlc_pkg and the frame_replacement_lru_clock_m rtl
`timescale 1ns / 1ps
module frame_replacement_lru_clock_m_tb;
  import frlc_pkg::*;

  typedef struct {
    idx_t        frame;
    logic        evicted;
    logic [31:0] page;
    logic        write_back;
  } alloc_result_t;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 3 * FRAMES + 8;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  command_i;
  logic [4:0]  frame_index_i;
  logic [31:0] page_id_i;
  logic [31:0] now_i;
  logic        result_valid_o;
  logic [4:0]  chosen_frame_o;
  logic        evicted_o;
  logic [31:0] evicted_page_o;
  logic        write_back_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  // frame table model
  mode_e       policy;
  bit          frame_occupied [FRAMES];
  bit          frame_used [FRAMES];
  bit          frame_dirty [FRAMES];
  bit [31:0]   frame_stamp [FRAMES];
  bit [31:0]   frame_page [FRAMES];
  idx_t        hand;

  alloc_result_t expected_allocs [$];
  alloc_result_t want;
  int unsigned   errors;
  int unsigned   idle_pct;
  int unsigned   words_sent;
  int unsigned   quiet_cycles;
  bit [31:0]     stamp_ms;

  frame_replacement_lru_clock_m i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .frame_index_i  (frame_index_i),
    .page_id_i      (page_id_i),
    .now_i          (now_i),
    .result_valid_o (result_valid_o),
    .chosen_frame_o (chosen_frame_o),
    .evicted_o      (evicted_o),
    .evicted_page_o (evicted_page_o),
    .write_back_o   (write_back_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic idx_t step_hand(idx_t h);
    return (h == idx_t'(FRAMES - 1)) ? '0 : idx_t'(h + 1'b1);
  endfunction

  function automatic idx_t lru_victim();
    idx_t oldest;
    oldest = '0;
    for (int i = 1; i < FRAMES; i++) begin
      if (frame_stamp[i] < frame_stamp[oldest]) oldest = idx_t'(i);
    end
    return oldest;
  endfunction

  // first lap takes unused clean frames, later laps unused dirty ones too
  function automatic idx_t clock_victim();
    idx_t first_pos;
    idx_t h;
    int   laps;
    first_pos = hand;
    laps = 0;
    for (int g = 0; g < 2 * FRAMES + 1; g++) begin
      h = hand;
      if (frame_occupied[h] && !frame_used[h] && (!frame_dirty[h] || laps > 0)) begin
        hand = step_hand(h);
        return h;
      end
      frame_used[h] = 1'b0;
      hand = step_hand(h);
      if (hand == first_pos) laps++;
    end
    h = hand;
    hand = step_hand(h);
    return h;
  endfunction

  task automatic update_frames(cmd_e cmd, idx_t idx, logic [31:0] page, logic [31:0] stamp);
    idx_t          f;
    bit            found;
    alloc_result_t r;
    case (cmd)
      CMD_READ: begin
        frame_used[idx] = 1'b1;
        frame_stamp[idx] = stamp;
      end
      CMD_WRITE: begin
        frame_used[idx] = 1'b1;
        frame_dirty[idx] = 1'b1;
      end
      CMD_ALLOC: begin
        found = 1'b0;
        f = '0;
        for (int i = 0; i < FRAMES; i++) begin
          if (!found && !frame_occupied[i]) begin
            f = idx_t'(i);
            found = 1'b1;
          end
        end
        if (!found) f = (policy == MODE_LRU) ? lru_victim() : clock_victim();
        r.frame = f;
        r.evicted = frame_occupied[f];
        r.page = frame_occupied[f] ? frame_page[f] : 32'd0;
        r.write_back = frame_occupied[f] && frame_dirty[f];
        expected_allocs.push_back(r);
        frame_occupied[f] = 1'b1;
        frame_used[f] = 1'b1;
        frame_dirty[f] = 1'b0;
        frame_page[f] = page;
        frame_stamp[f] = stamp;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(cmd_e cmd, idx_t idx, logic [31:0] page, logic [31:0] stamp);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    command_i <= cmd;
    frame_index_i <= idx;
    page_id_i <= page;
    now_i <= stamp;
    do @(posedge clk_i); while (busy);
    update_frames(cmd, idx, page, stamp);
    if (cmd != CMD_NONE) words_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_allocs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_policy(mode_e m);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    policy = m;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_word();
    int unsigned pick;
    logic [31:0] stamp;
    pick = $urandom_range(99);
    stamp_ms += $urandom_range(3);
    stamp = ($urandom_range(19) == 0) ? 32'($urandom) : stamp_ms;
    if (pick < 5) send_word(CMD_NONE, idx_t'($urandom_range(FRAMES - 1)), $urandom, stamp);
    else if (pick < 30) send_word(CMD_READ, idx_t'($urandom_range(FRAMES - 1)), $urandom, stamp);
    else if (pick < 55) send_word(CMD_WRITE, idx_t'($urandom_range(FRAMES - 1)), $urandom, stamp);
    else send_word(CMD_ALLOC, idx_t'($urandom_range(FRAMES - 1)), $urandom, stamp);
  endtask

  // touch every frame from a random offset, then allocate
  task automatic sweep_frames(cmd_e cmd);
    int unsigned offset;
    offset = $urandom_range(FRAMES - 1);
    for (int i = 0; i < FRAMES; i++) begin
      stamp_ms++;
      send_word(cmd, idx_t'((i + offset) % FRAMES), $urandom, stamp_ms);
    end
    stamp_ms++;
    send_word(CMD_ALLOC, idx_t'($urandom_range(FRAMES - 1)), $urandom, stamp_ms);
  endtask

  task automatic run_random(int unsigned n, cmd_e sweep_cmd);
    int unsigned target;
    target = words_sent + n;
    while (words_sent < target) begin
      if ($urandom_range(49) == 0) sweep_frames(sweep_cmd);
      else send_random_word();
    end
  endtask

  task automatic test_directed();
    set_policy(MODE_LRU);
    idle_pct = 0;
    send_word(CMD_READ, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_WRITE, 5'd0, 32'h0, 32'h0);
    send_word(CMD_NONE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_READ, 5'd5, 32'h0, 32'h1234_5678);
    send_word(CMD_ALLOC, 5'd0, 32'h0, 32'h0);
    send_word(CMD_ALLOC, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_WRITE, 5'd1, 32'h0, 32'h0);
    send_word(CMD_READ, 5'd0, 32'h0, 32'hFFFF_FFFF);
    send_word(CMD_NONE, 5'd0, 32'h0, 32'h0);
    send_word(CMD_WRITE, 5'd2, 32'h0, 32'h5);
    send_word(CMD_ALLOC, 5'd2, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_word(CMD_ALLOC, 5'd21, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    send_word(CMD_READ, 5'd3, 32'h0, 32'h8000_0000);
    send_word(CMD_WRITE, 5'd31, 32'h0, 32'h0);
    send_word(CMD_ALLOC, 5'd10, 32'h8000_0001, 32'h7FFF_FFFF);
    send_word(CMD_ALLOC, 5'd0, 32'h0000_0001, 32'h0000_0001);
    stamp_ms = 32'd100;
  endtask

  task automatic test_lru_replacement();
    set_policy(MODE_LRU);
    idle_pct = 0;
    run_random(320, CMD_READ);
  endtask

  task automatic test_clock_replacement();
    set_policy(MODE_CLOCK);
    idle_pct = 54;
    run_random(320, CMD_WRITE);
  endtask

  task automatic test_clock_back_to_back();
    set_policy(MODE_CLOCK);
    idle_pct = 0;
    run_random(220, CMD_READ);
  endtask

  task automatic test_light_idle();
    set_policy(MODE_LRU);
    idle_pct = 9;
    run_random(220, CMD_WRITE);
    set_policy(MODE_CLOCK);
    run_random(220, CMD_WRITE);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_allocs.size() == 0) begin
        $display("%0t: result with nothing expected: frame %0d evicted %0b page %h wb %0b",
                 $time, chosen_frame_o, evicted_o, evicted_page_o, write_back_o);
        errors++;
      end else begin
        want = expected_allocs.pop_front();
        if (chosen_frame_o !== want.frame) begin
          $display("%0t: chosen_frame expected %0d got %0d", $time, want.frame, chosen_frame_o);
          errors++;
        end
        if (evicted_o !== want.evicted) begin
          $display("%0t: evicted expected %0b got %0b", $time, want.evicted, evicted_o);
          errors++;
        end
        if (evicted_page_o !== want.page) begin
          $display("%0t: evicted_page expected %h got %h", $time, want.page, evicted_page_o);
          errors++;
        end
        if (write_back_o !== want.write_back) begin
          $display("%0t: write_back expected %0b got %0b", $time, want.write_back,
                   write_back_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    idle_pct = 0;
    words_sent = 0;
    quiet_cycles = 0;
    stamp_ms = '0;
    policy = MODE_LRU;
    hand = '0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    command_i <= CMD_NONE;
    frame_index_i <= '0;
    page_id_i <= '0;
    now_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_lru_replacement();
    test_clock_replacement();
    test_clock_back_to_back();
    test_light_idle();

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
